>>> rtl/core/ebalu_pkg.sv
// Shared operation codes, flag type and constants of the 8-bit CPU ALU.
`default_nettype none

package ebalu_pkg;

	// Operation codes; code 31 is unused and passes everything through
	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLC   = 5'd10,
		OP_RRC   = 5'd11,
		OP_RL    = 5'd12,
		OP_RR    = 5'd13,
		OP_SLA   = 5'd14,
		OP_SRA   = 5'd15,
		OP_SWAP  = 5'd16,
		OP_SRL   = 5'd17,
		OP_BIT   = 5'd18,
		OP_RES   = 5'd19,
		OP_SET   = 5'd20,
		OP_DAA   = 5'd21,
		OP_CPL   = 5'd22,
		OP_SCF   = 5'd23,
		OP_CCF   = 5'd24,
		OP_RLCA  = 5'd25,
		OP_RRCA  = 5'd26,
		OP_RLA   = 5'd27,
		OP_RRA   = 5'd28,
		OP_ADD16 = 5'd29,
		OP_ADDSP = 5'd30
	} op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	localparam logic [7:0] DAA_LIMIT   = 8'h99;
	localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
	localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
	localparam logic [3:0] DIGIT_LIMIT = 4'h9;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;

endpackage

`default_nettype wire

>>> rtl/core/ebalu_exec.sv
// Single-pass ALU datapath: result and new flags for one request.
`default_nettype none

module ebalu_exec (
	input  logic [4:0]        operation,
	input  logic [15:0]       operand_a,
	input  logic [15:0]       operand_b,
	input  logic [2:0]        bit_index,
	input  ebalu_pkg::flags_t flags_in,
	output logic [15:0]       result,
	output ebalu_pkg::flags_t flags_out
);

	ebalu_pkg::op_t op;
	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin_add;
	logic        cin_sub;
	logic [8:0]  sum9;
	logic [4:0]  hsum5;
	logic [8:0]  dif9;
	logic [4:0]  hdif5;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [16:0] sum17;
	logic [12:0] hsum13;
	logic [15:0] sp_sum;
	logic [8:0]  sp_c9;
	logic [4:0]  sp_h5;
	logic [7:0]  mask;
	logic        daa_hi;
	logic        daa_lo;
	logic [7:0]  daa_add;
	logic [7:0]  daa_sub;
	logic [7:0]  rot8;
	logic        rot_c;
	logic        is_acc;

	assign op = ebalu_pkg::op_t'(operation);
	assign a  = operand_a[7:0];
	assign b  = operand_b[7:0];

	// Carry-in only for the with-carry forms
	assign cin_add = (op == ebalu_pkg::OP_ADC) & flags_in.c;
	assign cin_sub = (op == ebalu_pkg::OP_SBC) & flags_in.c;

	assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
	assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
	assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
	assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};

	assign inc8 = a + 8'd1;
	assign dec8 = a - 8'd1;

	assign sum17  = {1'b0, operand_a} + {1'b0, operand_b};
	assign hsum13 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

	assign sp_sum = operand_a + {{8{b[7]}}, b};
	assign sp_c9  = {1'b0, operand_a[7:0]} + {1'b0, b};
	assign sp_h5  = {1'b0, operand_a[3:0]} + {1'b0, b[3:0]};

	assign mask = 8'd1 << bit_index;

	// Decimal adjust: low nibble is untouched by the high correction
	assign daa_hi  = flags_in.c | (a > ebalu_pkg::DAA_LIMIT);
	assign daa_lo  = flags_in.h | (a[3:0] > ebalu_pkg::DIGIT_LIMIT);
	assign daa_add = a + (daa_hi ? ebalu_pkg::DAA_ADJ_HI : ebalu_pkg::BYTE_ZERO)
		+ (daa_lo ? ebalu_pkg::DAA_ADJ_LO : ebalu_pkg::BYTE_ZERO);
	assign daa_sub = a - (flags_in.c ? ebalu_pkg::DAA_ADJ_HI : ebalu_pkg::BYTE_ZERO)
		- (flags_in.h ? ebalu_pkg::DAA_ADJ_LO : ebalu_pkg::BYTE_ZERO);

	assign is_acc = (op == ebalu_pkg::OP_RLCA) || (op == ebalu_pkg::OP_RRCA)
		|| (op == ebalu_pkg::OP_RLA) || (op == ebalu_pkg::OP_RRA);

	// Rotate and shift group
	always_comb begin
		rot8  = a;
		rot_c = 1'b0;
		case (op)
			ebalu_pkg::OP_RLC, ebalu_pkg::OP_RLCA: begin
				rot8  = {a[6:0], a[7]};
				rot_c = a[7];
			end
			ebalu_pkg::OP_RRC, ebalu_pkg::OP_RRCA: begin
				rot8  = {a[0], a[7:1]};
				rot_c = a[0];
			end
			ebalu_pkg::OP_RL, ebalu_pkg::OP_RLA: begin
				rot8  = {a[6:0], flags_in.c};
				rot_c = a[7];
			end
			ebalu_pkg::OP_RR, ebalu_pkg::OP_RRA: begin
				rot8  = {flags_in.c, a[7:1]};
				rot_c = a[0];
			end
			ebalu_pkg::OP_SLA: begin
				rot8  = {a[6:0], 1'b0};
				rot_c = a[7];
			end
			ebalu_pkg::OP_SRA: begin
				rot8  = {a[7], a[7:1]};
				rot_c = a[0];
			end
			ebalu_pkg::OP_SWAP: begin
				rot8  = {a[3:0], a[7:4]};
				rot_c = 1'b0;
			end
			ebalu_pkg::OP_SRL: begin
				rot8  = {1'b0, a[7:1]};
				rot_c = a[0];
			end
			default: begin
				rot8  = a;
				rot_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		result    = operand_a;
		flags_out = flags_in;
		case (op)
			ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
				result    = {ebalu_pkg::BYTE_ZERO, sum9[7:0]};
				flags_out = '{z: ~|sum9[7:0], n: 1'b0, h: hsum5[4], c: sum9[8]};
			end
			ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC: begin
				result    = {ebalu_pkg::BYTE_ZERO, dif9[7:0]};
				flags_out = '{z: ~|dif9[7:0], n: 1'b1, h: hdif5[4], c: dif9[8]};
			end
			ebalu_pkg::OP_CP: begin
				flags_out = '{z: ~|dif9[7:0], n: 1'b1, h: hdif5[4], c: dif9[8]};
			end
			ebalu_pkg::OP_AND: begin
				result    = {ebalu_pkg::BYTE_ZERO, a & b};
				flags_out = '{z: ~|(a & b), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			ebalu_pkg::OP_XOR: begin
				result    = {ebalu_pkg::BYTE_ZERO, a ^ b};
				flags_out = '{z: ~|(a ^ b), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			ebalu_pkg::OP_OR: begin
				result    = {ebalu_pkg::BYTE_ZERO, a | b};
				flags_out = '{z: ~|(a | b), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			ebalu_pkg::OP_INC: begin
				result    = {ebalu_pkg::BYTE_ZERO, inc8};
				flags_out = '{z: ~|inc8, n: 1'b0, h: &a[3:0], c: flags_in.c};
			end
			ebalu_pkg::OP_DEC: begin
				result    = {ebalu_pkg::BYTE_ZERO, dec8};
				flags_out = '{z: ~|dec8, n: 1'b1, h: &dec8[3:0], c: flags_in.c};
			end
			ebalu_pkg::OP_RLC, ebalu_pkg::OP_RRC, ebalu_pkg::OP_RL,
			ebalu_pkg::OP_RR, ebalu_pkg::OP_SLA, ebalu_pkg::OP_SRA,
			ebalu_pkg::OP_SWAP, ebalu_pkg::OP_SRL, ebalu_pkg::OP_RLCA,
			ebalu_pkg::OP_RRCA, ebalu_pkg::OP_RLA, ebalu_pkg::OP_RRA: begin
				result    = {ebalu_pkg::BYTE_ZERO, rot8};
				flags_out = '{z: ~is_acc & ~|rot8, n: 1'b0, h: 1'b0, c: rot_c};
			end
			ebalu_pkg::OP_BIT: begin
				flags_out = '{z: ~|(a & mask), n: 1'b0, h: 1'b1, c: flags_in.c};
			end
			ebalu_pkg::OP_RES: begin
				result = {ebalu_pkg::BYTE_ZERO, a & ~mask};
			end
			ebalu_pkg::OP_SET: begin
				result = {ebalu_pkg::BYTE_ZERO, a | mask};
			end
			ebalu_pkg::OP_DAA: begin
				if (flags_in.n) begin
					result    = {ebalu_pkg::BYTE_ZERO, daa_sub};
					flags_out = '{z: ~|daa_sub, n: 1'b1, h: 1'b0, c: flags_in.c};
				end else begin
					result    = {ebalu_pkg::BYTE_ZERO, daa_add};
					flags_out = '{z: ~|daa_add, n: 1'b0, h: 1'b0, c: daa_hi};
				end
			end
			ebalu_pkg::OP_CPL: begin
				result    = {ebalu_pkg::BYTE_ZERO, ~a};
				flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
			end
			ebalu_pkg::OP_SCF: begin
				flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			ebalu_pkg::OP_CCF: begin
				flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
			end
			ebalu_pkg::OP_ADD16: begin
				result    = sum17[15:0];
				flags_out = '{z: flags_in.z, n: 1'b0, h: hsum13[12], c: sum17[16]};
			end
			ebalu_pkg::OP_ADDSP: begin
				result    = sp_sum;
				flags_out = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
			end
			default: begin
				result    = operand_a;
				flags_out = flags_in;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/eight_bit_cpu_alu_with_flags_core.sv
// Top level of the 8-bit CPU ALU: request register, datapath, result register.
//
// Usage:
//   Input channel: in_valid / in_stall carry one request (operation, two
//   operands, bit index and the current Z, N, H, C flags). A request is
//   taken at a rising edge where in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall carry one result (16-bit value
//   and the new flags) per request, in request order.
//   Path: an accepted request is held in the request register, then goes
//   through one pass of the ALU datapath into the result register, which
//   drives out_valid and the result outputs.
//   Throughput: one request per cycle while the output is not stalled, set
//   by the single-pass datapath; stage 1 still fills while stage 2 is held.
//   Stall: while out_stall holds a waiting result, the request register
//   still takes one more request; in_stall rises only once both stages
//   are full and the output is stalled. A stalled result does not change.
//   Reset: arst_n low clears both valid bits at once; no results are
//   pending afterward and in_stall is low, so a request can be taken right away.
`default_nettype none

module eight_bit_cpu_alu_with_flags_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  operation,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic [2:0]  bit_index,
	input  logic        zero_in,
	input  logic        subtract_in,
	input  logic        half_in,
	input  logic        carry_in,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result,
	output logic        zero_out,
	output logic        subtract_out,
	output logic        half_out,
	output logic        carry_out
);

	// Request register (stage 1)
	logic              valid_s1;
	logic [4:0]        op_s1;
	logic [15:0]       a_s1;
	logic [15:0]       b_s1;
	logic [2:0]        bidx_s1;
	ebalu_pkg::flags_t flags_s1;

	// Result register (stage 2)
	logic              valid_s2;
	logic [15:0]       res_s2;
	ebalu_pkg::flags_t flags_s2;

	// Datapath outputs
	logic [15:0]       alu_res;
	ebalu_pkg::flags_t alu_flags;

	logic              load_s2;
	logic              load_s1;

	// Advance stage 2 whenever it is empty or its result is being taken
	assign load_s2  = ~valid_s2 | ~out_stall;
	// Stall requests only when stage 1 is full and cannot move on
	assign in_stall = valid_s1 & ~load_s2;
	assign load_s1  = ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: capture on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			op_s1    <= operation;
			a_s1     <= operand_a;
			b_s1     <= operand_b;
			bidx_s1  <= bit_index;
			flags_s1 <= '{z: zero_in, n: subtract_in, h: half_in, c: carry_in};
		end
		if (load_s2 && valid_s1) begin
			res_s2   <= alu_res;
			flags_s2 <= alu_flags;
		end
	end

	ebalu_exec u_exec (
		.operation (op_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.bit_index (bidx_s1),
		.flags_in  (flags_s1),
		.result    (alu_res),
		.flags_out (alu_flags)
	);

	// Drive the result channel straight from stage 2
	assign out_valid    = valid_s2;
	assign result       = res_s2;
	assign zero_out     = flags_s2.z;
	assign subtract_out = flags_s2.n;
	assign half_out     = flags_s2.h;
	assign carry_out    = flags_s2.c;

endmodule

`default_nettype wire

>>> rtl/core/ebalu_chk.sv
// Port-level checker for the 8-bit CPU ALU, bound to the top level.
`default_nettype none

module ebalu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [4:0]  operation,
	input logic [15:0] operand_a,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] result,
	input logic        zero_out,
	input logic        subtract_out,
	input logic        half_out,
	input logic        carry_out
);

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(zero_out)
			&& $stable(subtract_out) && $stable(half_out) && $stable(carry_out))
		else $error("stalled result changed");

	// Stall requests only when the output side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled while output is free");

	// An accepted request reaches the output through both registers when not blocked
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("result missing two cycles after request");

	// Compare gives the accumulator back unchanged
	a_cp_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == ebalu_pkg::OP_CP) ##1 !out_stall
			|=> result == $past(operand_a, 2))
		else $error("compare changed its operand");

endmodule

bind eight_bit_cpu_alu_with_flags_core ebalu_chk u_ebalu_chk (.*);

`default_nettype wire
